/* hw/rtl/dmsr_pkg.sv */
// dmsr_pkg: shared types and constants for the dual motor speed ramp.
// Used by every module under hw/rtl; depends on nothing.

package dmsr_pkg;

  localparam int SPEED_W = 8;
  localparam int DUTY_W  = 8;
  localparam int STEP_W  = 7;
  localparam int MAG_W   = 7;
  localparam int DELAY_W = 16;
  localparam int TIME_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // speed limits, held in the 10-bit ramp arithmetic width
  localparam int RAMP_W = 10;
  localparam logic signed [RAMP_W-1:0] SPEED_MAX = 10'sd100;
  localparam logic signed [RAMP_W-1:0] SPEED_MIN = -10'sd100;

  // x / 100 == (x * 5243) >> 19, exact for x < 43690 (product tops out at 25500)
  localparam int PROD_W    = DUTY_W + MAG_W;
  localparam int RECIP_W   = 13;
  localparam int DIV_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int SCALED_W  = PROD_W + RECIP_W;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ACCEL = 3'd0;
  localparam logic [2:0] REG_DECEL = 3'd1;
  localparam logic [2:0] REG_DELAY = 3'd2;
  localparam logic [2:0] REG_MIN   = 3'd3;
  localparam logic [2:0] REG_MAX   = 3'd4;

  localparam logic [0:0] CMD_UPDATE = 1'b0;
  localparam logic [0:0] CMD_ESTOP  = 1'b1;

  typedef struct packed {
    logic [STEP_W-1:0]  accel_step;
    logic [STEP_W-1:0]  decel_step;
    logic [DELAY_W-1:0] reverse_delay_ms;
    logic [DUTY_W-1:0]  duty_floor;
    logic [DUTY_W-1:0]  duty_ceil;
  } cfg_t;

  // per-lane result: the lane's state after the transaction
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      forward;
    logic                      quiet;    // speed zero and no reversal pending
  } lane_res_t;

endpackage

/* hw/rtl/dmsr_regs.sv */
// dmsr_regs: APB-style register file holding the ramp and duty settings.
// Depends on dmsr_pkg.

module dmsr_regs import dmsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ACCEL: cfg_nxt.accel_step       = pwdata[STEP_W-1:0];
        REG_DECEL: cfg_nxt.decel_step       = pwdata[STEP_W-1:0];
        REG_DELAY: cfg_nxt.reverse_delay_ms = pwdata[DELAY_W-1:0];
        REG_MIN:   cfg_nxt.duty_floor       = pwdata[DUTY_W-1:0];
        REG_MAX:   cfg_nxt.duty_ceil        = pwdata[DUTY_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step       <= STEP_W'(5);
      cfg_r.decel_step       <= STEP_W'(5);
      cfg_r.reverse_delay_ms <= DELAY_W'(200);
      cfg_r.duty_floor       <= DUTY_W'(0);
      cfg_r.duty_ceil        <= DUTY_W'(255);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ACCEL: prdata = DATA_W'(cfg_r.accel_step);
      REG_DECEL: prdata = DATA_W'(cfg_r.decel_step);
      REG_DELAY: prdata = DATA_W'(cfg_r.reverse_delay_ms);
      REG_MIN:   prdata = DATA_W'(cfg_r.duty_floor);
      REG_MAX:   prdata = DATA_W'(cfg_r.duty_ceil);
      default:   prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/dmsr_lane.sv */
// dmsr_lane: one motor channel - target clamp, reversal dead time and speed ramp.
// State updates in the cycle a transaction is accepted. Depends on dmsr_pkg.

module dmsr_lane import dmsr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      command,
  input  logic signed [SPEED_W-1:0] target,
  input  logic [TIME_W-1:0]         now_ms,
  input  cfg_t                      cfg,
  output lane_res_t                 res
);

  logic signed [SPEED_W-1:0] speed_r, speed_nxt;
  logic                      fwd_r, fwd_nxt;
  logic                      rev_r, rev_nxt;
  logic [TIME_W-1:0]         start_r, start_nxt;

  logic signed [RAMP_W-1:0]  tgt, cur, nxt, acc, dec;
  logic [TIME_W-1:0]         elapsed;
  logic                      delay_done;
  logic [RAMP_W-1:0]         cur_mag, tgt_mag;

  always_comb begin
    tgt = RAMP_W'(target);
    if (tgt > SPEED_MAX) tgt = SPEED_MAX;
    if (tgt < SPEED_MIN) tgt = SPEED_MIN;
  end

  assign cur        = RAMP_W'(speed_r);
  assign acc        = $signed({{(RAMP_W-STEP_W){1'b0}}, cfg.accel_step});
  assign dec        = $signed({{(RAMP_W-STEP_W){1'b0}}, cfg.decel_step});
  assign cur_mag    = (cur < 0) ? RAMP_W'(-cur) : RAMP_W'(cur);
  assign tgt_mag    = (tgt < 0) ? RAMP_W'(-tgt) : RAMP_W'(tgt);
  assign elapsed    = now_ms - start_r;
  assign delay_done = elapsed >= TIME_W'(cfg.reverse_delay_ms);

  // one ramp step toward the target, never passing it
  always_comb begin
    nxt = cur;
    if (cur_mag < tgt_mag) begin
      if (tgt > 0) begin
        nxt = cur + acc;
        if (nxt > tgt) nxt = tgt;
      end else begin
        nxt = cur - acc;
        if (nxt < tgt) nxt = tgt;
      end
    end else if (cur_mag > tgt_mag) begin
      if (cur > 0) begin
        nxt = cur - dec;
        if (nxt < tgt) nxt = tgt;
      end else begin
        nxt = cur + dec;
        if (nxt > tgt) nxt = tgt;
      end
    end
  end

  always_comb begin
    speed_nxt = speed_r;
    fwd_nxt   = fwd_r;
    rev_nxt   = rev_r;
    start_nxt = start_r;
    if (command == CMD_ESTOP) begin
      speed_nxt = '0;
      rev_nxt   = 1'b0;
    end else if (rev_r) begin
      if (delay_done) begin
        rev_nxt = 1'b0;
        fwd_nxt = (tgt >= 0);
      end
    end else if ((cur > 0 && tgt < 0) || (cur < 0 && tgt > 0)) begin
      speed_nxt = '0;
      rev_nxt   = 1'b1;
      start_nxt = now_ms;
    end else begin
      if (cur == 0 && tgt != 0) fwd_nxt = (tgt > 0);
      speed_nxt = SPEED_W'(nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      fwd_r   <= 1'b1;
      rev_r   <= 1'b0;
      start_r <= '0;
    end else if (en) begin
      speed_r <= speed_nxt;
      fwd_r   <= fwd_nxt;
      rev_r   <= rev_nxt;
      start_r <= start_nxt;
    end
  end

  assign res.speed   = speed_nxt;
  assign res.forward = fwd_nxt;
  assign res.quiet   = (speed_nxt == 0) && !rev_nxt;

endmodule

/* hw/rtl/dmsr_duty.sv */
// dmsr_duty: two-stage duty scaling, min + (max-min)*|speed|/100, and zero duty at zero speed.
// Stage A multiplies, stage B divides by 100 through a reciprocal. Depends on dmsr_pkg.

module dmsr_duty import dmsr_pkg::*; (
  input  logic                      clk,
  input  logic                      en_a,
  input  logic                      en_b,
  input  logic signed [SPEED_W-1:0] speed,
  input  cfg_t                      cfg,
  output logic [DUTY_W-1:0]         duty
);

  logic [MAG_W-1:0]    mag;
  logic [DUTY_W-1:0]   span;
  logic                inv;
  logic [PROD_W-1:0]   prod_r;
  logic [DUTY_W-1:0]   min_r;
  logic                inv_r, zero_r;
  logic [SCALED_W-1:0] scaled;
  logic [DUTY_W-1:0]   quot;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;

  assign mag  = (speed < 0) ? MAG_W'(-speed) : MAG_W'(speed);
  assign inv  = cfg.duty_floor > cfg.duty_ceil;
  assign span = inv ? (cfg.duty_floor - cfg.duty_ceil) : (cfg.duty_ceil - cfg.duty_floor);

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r <= PROD_W'(span) * PROD_W'(mag);
      min_r  <= cfg.duty_floor;
      inv_r  <= inv;
      zero_r <= (mag == '0);
    end
  end

  assign scaled = SCALED_W'(prod_r) * SCALED_W'(RECIP_100);
  assign quot   = scaled[DIV_SHIFT +: DUTY_W];

  always_comb begin
    if (zero_r) duty_nxt = '0;
    else if (inv_r) duty_nxt = min_r - quot;
    else duty_nxt = min_r + quot;
  end

  always_ff @(posedge clk) begin
    if (en_b) duty_r <= duty_nxt;
  end

  assign duty = duty_r;

endmodule

/* hw/rtl/dual_motor_speed_ramp.sv */
// dual_motor_speed_ramp: top level, two ramp lanes, duty pipeline and result merge.
// Depends on dmsr_pkg, dmsr_regs, dmsr_lane, dmsr_duty.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction: an update
//   with signed left/right targets and a millisecond timestamp, or an emergency stop.
//   Output channel (out_valid/out_ready) returns exactly one result per input
//   transaction: both duties, directions, ramped speeds and the all-stopped flag,
//   showing the motor state after that transaction.
//   Both lanes update their state in the accept cycle; the duty scaling follows in
//   two registered stages (multiply, then divide by 100 via a reciprocal multiply).
//   Each transaction passes the lane result, product and duty registers in order;
//   out_valid is the duty stage's valid bit. Throughput: one transaction per cycle while
//   out_ready is high; each stage holds its own valid bit, so bubbles fill while
//   the receiver stalls and up to three results are in flight.
//   When the receiver stalls with the pipe full, in_ready drops until out_ready.
//   Reset (rst_n low, synchronous) empties the pipe, sets speeds to 0, directions
//   forward, clears reversals and loads register defaults.
//   The APB-style port at byte address 4*i holds accel, decel, reverse delay,
//   min duty, max duty; write it only while no transaction is in flight.

module dual_motor_speed_ramp import dmsr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic signed [SPEED_W-1:0] in_left_target,
  input  logic signed [SPEED_W-1:0] in_right_target,
  input  logic [TIME_W-1:0]         in_now_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DUTY_W-1:0]         out_left_duty,
  output logic [DUTY_W-1:0]         out_right_duty,
  output logic                      out_left_forward,
  output logic                      out_right_forward,
  output logic signed [SPEED_W-1:0] out_left_speed,
  output logic signed [SPEED_W-1:0] out_right_speed,
  output logic                      out_all_stopped,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  cfg_t      cfg;
  lane_res_t left_res, right_res;
  lane_res_t l1_r, r1_r, l2_r, r2_r, l3_r, r3_r;
  logic      stop1_r, stop2_r, stop3_r;
  logic      v1_r, v2_r, v3_r;
  logic      v1_nxt, v2_nxt, v3_nxt;
  logic      ld1, ld2, ld3;

  // per-stage load: a stage takes new data when empty or when it drains this cycle
  assign ld3      = v2_r && (!v3_r || out_ready);
  assign ld2      = v1_r && (!v2_r || ld3);
  assign in_ready = !v1_r || ld2;
  assign ld1      = in_valid && in_ready;

  dmsr_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  dmsr_lane u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (ld1),
    .command(in_command),
    .target (in_left_target),
    .now_ms (in_now_ms),
    .cfg    (cfg),
    .res    (left_res)
  );

  dmsr_lane u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (ld1),
    .command(in_command),
    .target (in_right_target),
    .now_ms (in_now_ms),
    .cfg    (cfg),
    .res    (right_res)
  );

  dmsr_duty u_left_duty (
    .clk  (clk),
    .en_a (ld2),
    .en_b (ld3),
    .speed(l1_r.speed),
    .cfg  (cfg),
    .duty (out_left_duty)
  );

  dmsr_duty u_right_duty (
    .clk  (clk),
    .en_a (ld2),
    .en_b (ld3),
    .speed(r1_r.speed),
    .cfg  (cfg),
    .duty (out_right_duty)
  );

  always_comb begin
    v1_nxt = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_r);
    v2_nxt = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_r);
    v3_nxt = ld3 ? 1'b1 : ((v3_r && out_ready) ? 1'b0 : v3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // merge: both lanes quiet means all stopped
  always_ff @(posedge clk) begin
    if (ld1) begin
      l1_r    <= left_res;
      r1_r    <= right_res;
      stop1_r <= left_res.quiet && right_res.quiet;
    end
    if (ld2) begin
      l2_r    <= l1_r;
      r2_r    <= r1_r;
      stop2_r <= stop1_r;
    end
    if (ld3) begin
      l3_r    <= l2_r;
      r3_r    <= r2_r;
      stop3_r <= stop2_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_left_forward  = l3_r.forward;
  assign out_right_forward = r3_r.forward;
  assign out_left_speed    = l3_r.speed;
  assign out_right_speed   = r3_r.speed;
  assign out_all_stopped   = stop3_r;

endmodule

/* hw/rtl/dmsr_checker.sv */
// dmsr_checker: port-level assertions for dual_motor_speed_ramp, bound to the top.
// Depends on dmsr_pkg.

module dmsr_checker import dmsr_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [DUTY_W-1:0]         out_left_duty,
  input logic [DUTY_W-1:0]         out_right_duty,
  input logic signed [SPEED_W-1:0] out_left_speed,
  input logic signed [SPEED_W-1:0] out_right_speed,
  input logic                      out_all_stopped
);

  // stalled result transaction must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_speed) &&
      $stable(out_right_speed) && $stable(out_left_duty) && $stable(out_right_duty))
    else $error("result changed while stalled");

  a_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_all_stopped |-> out_left_speed == 0 && out_right_speed == 0)
    else $error("all_stopped with nonzero speed");

  a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_speed != 0 || out_left_duty == 0) &&
      (out_right_speed != 0 || out_right_duty == 0))
    else $error("nonzero duty at zero speed");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_speed <= 8'sd100 && out_left_speed >= -8'sd100 &&
      out_right_speed <= 8'sd100 && out_right_speed >= -8'sd100)
    else $error("speed out of range");

endmodule

bind dual_motor_speed_ramp dmsr_checker u_dmsr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_left_duty  (out_left_duty),
  .out_right_duty (out_right_duty),
  .out_left_speed (out_left_speed),
  .out_right_speed(out_right_speed),
  .out_all_stopped(out_all_stopped)
);

/* sim/dual_motor_speed_ramp_test.sv */
// Self-checking testbench for dual_motor_speed_ramp: directed and random motor commands
// with ramp, reversal, dead-time, e-stop and duty prediction. Depends on dmsr_pkg.
`timescale 1ns / 100ps

module dual_motor_speed_ramp_test;
  import dmsr_pkg::*;

  typedef struct packed {
    logic [0:0]                cmd;
    logic signed [SPEED_W-1:0] left_tgt;
    logic signed [SPEED_W-1:0] right_tgt;
    logic [TIME_W-1:0]         now_ms;
  } motor_cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0]         left_duty;
    logic [DUTY_W-1:0]         right_duty;
    logic                      left_fwd;
    logic                      right_fwd;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      stopped;
  } motor_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_UPDATE;
  logic signed [SPEED_W-1:0] in_left_target = '0;
  logic signed [SPEED_W-1:0] in_right_target = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DUTY_W-1:0] out_left_duty, out_right_duty;
  logic out_left_forward, out_right_forward;
  logic signed [SPEED_W-1:0] out_left_speed, out_right_speed;
  logic out_all_stopped;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  dual_motor_speed_ramp dut (.*);

  // predictor copy of the register file
  logic [STEP_W-1:0]  ramp_accel;
  logic [STEP_W-1:0]  ramp_decel;
  logic [DELAY_W-1:0] dead_ms;
  logic [DUTY_W-1:0]  duty_lo;
  logic [DUTY_W-1:0]  duty_hi;

  // predictor copy of the per-motor state, index 0 left, 1 right
  int                motor_speed [2];
  logic [DUTY_W-1:0] motor_duty [2];
  logic              motor_fwd [2];
  logic              motor_rev [2];
  logic [TIME_W-1:0] motor_rev_t0 [2];

  motor_cmd_t   cmd_q [$];
  motor_state_t due_states [$];

  int cmds_queued = 0;
  int cmds_taken = 0;
  int results_seen = 0;
  int bad_results = 0;
  int reversals_done = 0;
  int backpressure_cycles = 0;
  int holdoffs = 0;
  int settings_run = 0;
  logic in_taken = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d commands taken, %0d results checked", cmds_taken, results_seen);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_for(input int spd);
    int s;
    s = mag(spd);
    if (s == 0) return '0;
    if (duty_hi >= duty_lo)
      return DUTY_W'(int'(duty_lo) + ((int'(duty_hi) - int'(duty_lo)) * s) / 100);
    return DUTY_W'(int'(duty_lo) - ((int'(duty_lo) - int'(duty_hi)) * s) / 100);
  endfunction

  task automatic reset_motors();
    ramp_accel = 7'd5;
    ramp_decel = 7'd5;
    dead_ms = 16'd200;
    duty_lo = 8'd0;
    duty_hi = 8'd255;
    for (int k = 0; k < 2; k++) begin
      motor_speed[k] = 0;
      motor_duty[k] = '0;
      motor_fwd[k] = 1'b1;
      motor_rev[k] = 1'b0;
      motor_rev_t0[k] = '0;
    end
  endtask

  task automatic ramp_motor(input int k, input logic signed [SPEED_W-1:0] raw,
                            input logic [TIME_W-1:0] now);
    int tgt;
    int cur;
    logic [TIME_W-1:0] elapsed;
    tgt = raw;
    if (tgt > 100) tgt = 100;
    if (tgt < -100) tgt = -100;
    cur = motor_speed[k];
    if (motor_rev[k]) begin
      elapsed = now - motor_rev_t0[k];
      if (elapsed >= {16'd0, dead_ms}) begin
        motor_rev[k] = 1'b0;
        motor_fwd[k] = (tgt >= 0);
        reversals_done++;
      end
      return;
    end
    if ((cur > 0 && tgt < 0) || (cur < 0 && tgt > 0)) begin
      motor_speed[k] = 0;
      motor_duty[k] = '0;
      motor_rev[k] = 1'b1;
      motor_rev_t0[k] = now;
      return;
    end
    if (cur == 0 && tgt != 0) motor_fwd[k] = (tgt > 0);
    if (mag(cur) < mag(tgt)) begin
      if (tgt > 0) begin
        cur += int'(ramp_accel);
        if (cur > tgt) cur = tgt;
      end else begin
        cur -= int'(ramp_accel);
        if (cur < tgt) cur = tgt;
      end
    end else if (mag(cur) > mag(tgt)) begin
      if (cur > 0) begin
        cur -= int'(ramp_decel);
        if (cur < tgt) cur = tgt;
      end else begin
        cur += int'(ramp_decel);
        if (cur > tgt) cur = tgt;
      end
    end
    motor_speed[k] = cur;
    motor_duty[k] = duty_for(cur);
  endtask

  task automatic advance_motors(input motor_cmd_t c, output motor_state_t st);
    if (c.cmd == CMD_ESTOP) begin
      for (int k = 0; k < 2; k++) begin
        motor_speed[k] = 0;
        motor_duty[k] = '0;
        motor_rev[k] = 1'b0;
      end
    end else begin
      ramp_motor(0, c.left_tgt, c.now_ms);
      ramp_motor(1, c.right_tgt, c.now_ms);
    end
    st.left_duty = motor_duty[0];
    st.right_duty = motor_duty[1];
    st.left_fwd = motor_fwd[0];
    st.right_fwd = motor_fwd[1];
    st.left_speed = SPEED_W'(motor_speed[0]);
    st.right_speed = SPEED_W'(motor_speed[1]);
    st.stopped = (motor_speed[0] == 0 && motor_speed[1] == 0 &&
                  !motor_rev[0] && !motor_rev[1]);
  endtask

  // input side: bursts of back-to-back transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    motor_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_command <= c.cmd;
        in_left_target <= c.left_tgt;
        in_right_target <= c.right_tgt;
        in_now_ms <= c.now_ms;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: stall mode and pattern are redrawn periodically; a long hold-off now and then
  int rcv_cycle = 0;
  int stall_mode = 0;
  logic [7:0] stall_pat = 8'hff;
  int hold_left = 0;
  int next_hold = 150;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rst_n && in_valid && results_seen >= next_hold) begin
      hold_left = 40;
      next_hold += 350;
      holdoffs++;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= stall_pat[3'(rcv_cycle % 8)];
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
    rcv_cycle++;
    if (rcv_cycle % 200 == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_pat = 8'($urandom) | 8'h01;
    end
  end

  // acceptance, prediction and checking
  always @(posedge clk) begin
    motor_state_t st;
    motor_state_t got;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && !in_ready) backpressure_cycles++;
    if (rst_n && in_valid && in_ready) begin
      advance_motors('{in_command, in_left_target, in_right_target, in_now_ms}, st);
      due_states.push_back(st);
      cmds_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{out_left_duty, out_right_duty, out_left_forward, out_right_forward,
              out_left_speed, out_right_speed, out_all_stopped};
      results_seen++;
      if (due_states.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d arrived with no transaction outstanding", results_seen);
      end else begin
        st = due_states.pop_front();
        if (got !== st) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("result %0d: exp duty %0d/%0d fwd %b/%b speed %0d/%0d stop %b",
                     results_seen, st.left_duty, st.right_duty, st.left_fwd, st.right_fwd,
                     st.left_speed, st.right_speed, st.stopped);
            $display("  got duty %0d/%0d fwd %b/%b speed %0d/%0d stop %b",
                     got.left_duty, got.right_duty, got.left_fwd, got.right_fwd,
                     got.left_speed, got.right_speed, got.stopped);
          end
        end
      end
    end
  end

  task automatic push_cmd(input logic [0:0] cmd, input int lt, input int rt,
                          input logic [TIME_W-1:0] now);
    cmd_q.push_back('{cmd, SPEED_W'(lt), SPEED_W'(rt), now});
    cmds_queued++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ACCEL: ramp_accel = val[STEP_W-1:0];
      REG_DECEL: ramp_decel = val[STEP_W-1:0];
      REG_DELAY: dead_ms = val[DELAY_W-1:0];
      REG_MIN:   duty_lo = val[DUTY_W-1:0];
      REG_MAX:   duty_hi = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_ramp(input int acc, input int dec, input int dly, input int lo, input int hi);
    write_reg(REG_ACCEL, acc);
    write_reg(REG_DECEL, dec);
    write_reg(REG_DELAY, dly);
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
    settings_run++;
  endtask

  // block until every queued transaction has been accepted and answered
  task automatic wait_idle();
    while (cmds_taken != cmds_queued || due_states.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_target(input int held);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(0, 1) ? 100 : -100;
      2: return $urandom_range(0, 1) ? $urandom_range(101, 127) : -$urandom_range(101, 128);
      3: return -held;
      default: return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  logic [TIME_W-1:0] clock_ms = '0;
  int hold_l = 0;
  int hold_r = 0;

  // mostly steady target streams on an advancing clock, with e-stops and noise mixed in
  task automatic queue_random(input int n, input int dt_max);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        push_cmd(CMD_ESTOP, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      end else if (r < 8) begin
        push_cmd(CMD_UPDATE, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      end else begin
        if ($urandom_range(0, 4) == 0) hold_l = pick_target(hold_l);
        if ($urandom_range(0, 4) == 0) hold_r = pick_target(hold_r);
        clock_ms += $urandom_range(0, dt_max);
        push_cmd(CMD_UPDATE, hold_l, hold_r, clock_ms);
      end
    end
  endtask

  initial begin
    reset_motors();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: clamping, start from rest, reversal dead time, e-stop, time wrap
    push_cmd(CMD_UPDATE, 0, 0, 32'd0);
    push_cmd(CMD_UPDATE, 127, -128, 32'd10);
    push_cmd(CMD_UPDATE, 100, -100, 32'd20);
    push_cmd(CMD_UPDATE, 101, -101, 32'd30);
    push_cmd(CMD_UPDATE, 0, -40, 32'd40);
    push_cmd(CMD_UPDATE, -1, 1, 32'd100);
    push_cmd(CMD_UPDATE, -50, 50, 32'd200);
    push_cmd(CMD_UPDATE, -50, 50, 32'd299);
    push_cmd(CMD_UPDATE, -50, 50, 32'd300);
    push_cmd(CMD_UPDATE, -50, 50, 32'd310);
    push_cmd(CMD_ESTOP, 127, -128, 32'hffff_ffff);
    push_cmd(CMD_UPDATE, 0, 0, 32'hffff_fff0);
    push_cmd(CMD_UPDATE, 30, -30, 32'hffff_ffff);
    push_cmd(CMD_UPDATE, -30, 30, 32'hffff_ffff);
    push_cmd(CMD_UPDATE, -30, 30, 32'd198);
    push_cmd(CMD_UPDATE, -30, 30, 32'd199);
    push_cmd(CMD_UPDATE, 40, 40, 32'd300);
    push_cmd(CMD_UPDATE, -40, -40, 32'd310);
    push_cmd(CMD_ESTOP, 0, 0, 32'd320);
    push_cmd(CMD_UPDATE, -85, 85, 32'h5555_5555);
    push_cmd(CMD_UPDATE, -85, 85, 32'haaaa_aaaa);
    wait_idle();

    set_ramp(5, 5, 200, 0, 255);
    queue_random(250, 60);
    wait_idle();
    set_ramp(1, 100, 0, 0, 255);
    queue_random(150, 10);
    wait_idle();
    // inverted duty range and the longest dead time
    set_ramp(100, 1, 65535, 255, 0);
    queue_random(150, 20000);
    wait_idle();
    // zero steps: speed never ramps; it only drops to zero on an e-stop or a reversal
    set_ramp(0, 0, 5, 20, 200);
    queue_random(80, 10);
    wait_idle();
    set_ramp(127, 127, 50, 255, 255);
    clock_ms = 32'hffff_fe00;
    queue_random(150, 40);
    wait_idle();
    for (int p = 0; p < 3; p++) begin
      set_ramp($urandom_range(1, 127), $urandom_range(1, 127), $urandom_range(0, 400),
               $urandom_range(0, 255), $urandom_range(0, 255));
      queue_random(160, 80);
      wait_idle();
    end

    bad_results += due_states.size();
    $display("%0d transactions checked over %0d register settings, %0d reversals completed",
             results_seen, settings_run, reversals_done);
    $display("%0d receiver hold-offs, %0d cycles of input back-pressure, %0d failures",
             holdoffs, backpressure_cycles, bad_results);
    if (bad_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
